### hdl/bda_pkg.sv
package bda_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_BITS  = 16;
    localparam int NOW_BITS  = 32;
    localparam int IDX_BITS  = 2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CFG_BITS-1:0]  cfg_t;

    // button sets, bit0 decrement, bit1 increment
    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_DEC   = 2'd1,
        BTN_INC   = 2'd2,
        BTN_CHORD = 2'd3
    } btn_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_DEBOUNCE_TIME      = 2'd0,
        REG_FIRST_REPEAT_DELAY = 2'd1,
        REG_REPEAT_INTERVAL    = 2'd2
    } reg_idx_t;

    localparam cfg_t DEBOUNCE_TIME_RST      = CFG_BITS'(20);
    localparam cfg_t FIRST_REPEAT_DELAY_RST = CFG_BITS'(500);
    localparam cfg_t REPEAT_INTERVAL_RST    = CFG_BITS'(100);

    // deadline reached when the wrapping difference is not negative
    function automatic logic time_reached(time_t now, time_t limit);
        time_t diff;
        diff = now - limit;
        return ~diff[TIME_BITS-1];
    endfunction

endpackage

### hdl/bda_if.sv
interface bda_in_if;
    logic                           valid;
    logic                           ready;
    logic [bda_pkg::NOW_BITS-1:0]   now_ms;
    logic                           dec_pressed;
    logic                           inc_pressed;

    modport source (output valid, output now_ms, output dec_pressed, output inc_pressed,
                    input ready);
    modport sink (input valid, input now_ms, input dec_pressed, input inc_pressed,
                  output ready);
endinterface

interface bda_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  press_code;

    modport source (output valid, output press_code, input ready);
    modport sink (input valid, input press_code, output ready);
endinterface

### hdl/button_debounce_autorepeat.sv
// Two-button qualifier with debounce, release lockout and auto-repeat. Each input item is
// one sample of both button levels with its millisecond time; each item gives exactly one
// result item carrying press_code (0 none, 1 decrement, 2 increment, 3 both). An item is
// taken in every clock cycle unless the result register stalls: it is registered on
// acceptance, evaluated against the button state while held in the input register and
// loaded into the result register when it advances. The rate is set only by the result
// register: while a result waits to be taken, the one item already registered waits too
// and input ready drops. Configuration registers are written through cfg_we, cfg_index
// and cfg_data; the user must do so only while no item is in flight, as the block does
// not enforce it. Indexes beyond 2 are ignored.
module button_debounce_autorepeat (
    input  logic                           clk,
    input  logic                           rst_n,
    bda_in_if.sink                         in_ch,
    bda_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [bda_pkg::IDX_BITS-1:0]   cfg_index,
    input  logic [bda_pkg::CFG_BITS-1:0]   cfg_data
);

    bda_pkg::cfg_t debounce_time_reg;
    bda_pkg::cfg_t first_repeat_delay_reg;
    bda_pkg::cfg_t repeat_interval_reg;

    // input register
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    bda_pkg::time_t                s1_now_reg;
    bda_pkg::btn_t                 s1_cur_reg;

    // button state
    bda_pkg::btn_t                 held_reg;
    bda_pkg::btn_t                 held_next;
    bda_pkg::time_t                deadline_reg;
    bda_pkg::time_t                deadline_next;
    logic                          debounce_reg;
    logic                          debounce_next;
    logic                          emitted_reg;
    logic                          emitted_next;
    logic                          repeat_reg;
    logic                          repeat_next;

    // result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [1:0]                    press_code_reg;

    logic                          advance;
    logic                          in_accept;
    logic [1:0]                    code;
    logic                          go;
    bda_pkg::time_t                dl;
    bda_pkg::time_t                dbt;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_accept = in_ch.valid && in_ch.ready;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.press_code = press_code_reg;

    assign dbt = bda_pkg::TIME_BITS'(debounce_time_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg      <= bda_pkg::DEBOUNCE_TIME_RST;
            first_repeat_delay_reg <= bda_pkg::FIRST_REPEAT_DELAY_RST;
            repeat_interval_reg    <= bda_pkg::REPEAT_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bda_pkg::REG_DEBOUNCE_TIME:      debounce_time_reg      <= cfg_data;
                bda_pkg::REG_FIRST_REPEAT_DELAY: first_repeat_delay_reg <= cfg_data;
                bda_pkg::REG_REPEAT_INTERVAL:    repeat_interval_reg    <= cfg_data;
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        held_next     = held_reg;
        deadline_next = deadline_reg;
        debounce_next = debounce_reg;
        emitted_next  = emitted_reg;
        repeat_next   = repeat_reg;
        code          = bda_pkg::BTN_NONE;
        go            = 1'b1;
        dl            = deadline_reg;

        if (s1_cur_reg == bda_pkg::BTN_NONE && held_reg == bda_pkg::BTN_NONE)
        begin
            go = 1'b0;
        end
        else if (s1_cur_reg > held_reg)
        begin
            go = 1'b0;
            // from idle a press waits out the release lockout
            if (!(held_reg == bda_pkg::BTN_NONE
                  && !bda_pkg::time_reached(s1_now_reg, deadline_reg)))
            begin
                held_next     = s1_cur_reg;
                emitted_next  = 1'b0;
                repeat_next   = (s1_cur_reg == bda_pkg::BTN_DEC
                                 || s1_cur_reg == bda_pkg::BTN_INC);
                debounce_next = 1'b1;
                deadline_next = s1_now_reg + dbt;
            end
        end
        else
        begin
            if (debounce_reg)
            begin
                if (!bda_pkg::time_reached(s1_now_reg, deadline_reg))
                begin
                    go = 1'b0;
                end
                else
                begin
                    debounce_next = 1'b0;
                    dl = deadline_reg + bda_pkg::TIME_BITS'(first_repeat_delay_reg) - dbt;
                end
            end

            // partial release stalls
            if (go && !(s1_cur_reg != bda_pkg::BTN_NONE && s1_cur_reg < held_reg))
            begin
                if (s1_cur_reg == bda_pkg::BTN_NONE)
                begin
                    if (!emitted_reg)
                    begin
                        code = held_reg;
                    end
                    held_next = bda_pkg::BTN_NONE;
                    dl = s1_now_reg + dbt;
                end
                else if (!repeat_reg)
                begin
                    if (!emitted_reg)
                    begin
                        code = held_reg;
                    end
                end
                else if (bda_pkg::time_reached(s1_now_reg, dl))
                begin
                    code = held_reg;
                    dl = dl + bda_pkg::TIME_BITS'(repeat_interval_reg);
                end

                if (code != bda_pkg::BTN_NONE)
                begin
                    emitted_next = 1'b1;
                end
            end
            deadline_next = dl;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= bda_pkg::BTN_NONE;
            deadline_reg  <= '0;
            debounce_reg  <= 1'b0;
            emitted_reg   <= 1'b0;
            repeat_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                held_reg     <= held_next;
                deadline_reg <= deadline_next;
                debounce_reg <= debounce_next;
                emitted_reg  <= emitted_next;
                repeat_reg   <= repeat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_now_reg <= bda_pkg::TIME_BITS'(in_ch.now_ms);
            s1_cur_reg <= bda_pkg::btn_t'({in_ch.inc_pressed, in_ch.dec_pressed});
        end
        if (advance)
        begin
            press_code_reg <= code;
        end
    end

endmodule

### hdl/bda_checker.sv
module bda_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  press_code
);

    logic last_chord_reg;

    // remembers whether the last delivered item was the chord
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_chord_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            last_chord_reg <= (press_code == bda_pkg::BTN_CHORD);
        end
    end

    // a waiting result holds its code
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(press_code))
        else $error("result changed while stalled");

    // a fresh result comes from an item accepted into the input register before it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching item");

    // input is never blocked while the result register is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // the chord is reported once per press
    a_chord_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && press_code == bda_pkg::BTN_CHORD |-> !last_chord_reg)
        else $error("chord reported twice in a row");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown right after reset");

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .press_code (out_ch.press_code)
);

### sim/testbench.sv
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES = 6;
    // index 3 has no register behind it
    localparam logic [bda_pkg::IDX_BITS-1:0] REG_SPARE = 2'd3;

    class press_scoreboard;
        bda_pkg::cfg_t  deb_len_ms;
        bda_pkg::cfg_t  first_delay_ms;
        bda_pkg::cfg_t  interval_ms;
        bda_pkg::btn_t  held;
        bda_pkg::time_t deadline_ms;
        bit             debouncing;
        bit             emitted;
        bit             repeating;
        bda_pkg::btn_t  pending_codes[$];
        int             errors;

        function new();
            deb_len_ms     = 16'd20;
            first_delay_ms = 16'd500;
            interval_ms    = 16'd100;
            held           = bda_pkg::BTN_NONE;
            deadline_ms    = '0;
            debouncing     = 1'b0;
            emitted        = 1'b0;
            repeating      = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(logic [bda_pkg::IDX_BITS-1:0] idx, bda_pkg::cfg_t val);
            case (idx)
                bda_pkg::REG_DEBOUNCE_TIME:      deb_len_ms = val;
                bda_pkg::REG_FIRST_REPEAT_DELAY: first_delay_ms = val;
                bda_pkg::REG_REPEAT_INTERVAL:    interval_ms = val;
                default: ;
            endcase
        endfunction

        // sign of the wrapping difference decides
        function bit is_reached(bda_pkg::time_t t);
            bda_pkg::time_t gap;
            gap = t - deadline_ms;
            return gap[bda_pkg::TIME_BITS-1] == 1'b0;
        endfunction

        function void note_sample(bda_pkg::time_t t, logic dec, logic inc);
            bda_pkg::btn_t cur;
            bda_pkg::btn_t code;
            bit            settled;
            cur = bda_pkg::btn_t'({inc, dec});
            code = bda_pkg::BTN_NONE;
            if (!(cur == bda_pkg::BTN_NONE && held == bda_pkg::BTN_NONE))
            begin
                if (cur > held)
                begin
                    // from idle the release lockout holds the press off
                    if (held != bda_pkg::BTN_NONE || is_reached(t))
                    begin
                        held        = cur;
                        emitted     = 1'b0;
                        repeating   = (cur == bda_pkg::BTN_DEC || cur == bda_pkg::BTN_INC);
                        debouncing  = 1'b1;
                        deadline_ms = t + bda_pkg::time_t'(deb_len_ms);
                    end
                end
                else
                begin
                    settled = 1'b1;
                    if (debouncing)
                    begin
                        if (is_reached(t))
                        begin
                            debouncing  = 1'b0;
                            deadline_ms = deadline_ms + bda_pkg::time_t'(first_delay_ms)
                                          - bda_pkg::time_t'(deb_len_ms);
                        end
                        else
                        begin
                            settled = 1'b0;
                        end
                    end
                    // a partial release just stalls
                    if (settled && !(cur != bda_pkg::BTN_NONE && cur < held))
                    begin
                        if (cur == bda_pkg::BTN_NONE)
                        begin
                            if (!emitted)
                                code = held;
                            held        = bda_pkg::BTN_NONE;
                            deadline_ms = t + bda_pkg::time_t'(deb_len_ms);
                        end
                        else if (!repeating)
                        begin
                            if (!emitted)
                                code = held;
                        end
                        else if (is_reached(t))
                        begin
                            code        = held;
                            deadline_ms = deadline_ms + bda_pkg::time_t'(interval_ms);
                        end
                    end
                end
            end
            if (code != bda_pkg::BTN_NONE)
                emitted = 1'b1;
            pending_codes.push_back(code);
        endfunction

        function void check_code(logic [1:0] got);
            bda_pkg::btn_t want;
            if (pending_codes.size() == 0)
            begin
                $error("press_code: result with no item pending, actual %0d", got);
                errors++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (got !== want)
                begin
                    $error("press_code mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [bda_pkg::IDX_BITS-1:0] cfg_index;
    bda_pkg::cfg_t cfg_data;

    bda_in_if  in_ch();
    bda_out_if out_ch();

    button_debounce_autorepeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    press_scoreboard sb = new();
    bit             in_idle;
    bit             out_idle;
    int             sent;
    int             cycle_count;
    bda_pkg::time_t now_cur;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ch.ready <= (out_idle && $urandom_range(0, 99) < 20) ? 1'b0 : 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_code(out_ch.press_code);
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input bda_pkg::time_t t, input logic dec, input logic inc);
        while (in_idle && $urandom_range(0, 99) < 20)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.now_ms      <= t;
        in_ch.dec_pressed <= dec;
        in_ch.inc_pressed <= inc;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_sample(t, dec, inc);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        while (sb.pending_codes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [bda_pkg::IDX_BITS-1:0] idx,
                             input bda_pkg::cfg_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    // time gaps scaled to the current register settings
    function automatic bda_pkg::time_t pick_gap();
        int unsigned deb;
        int unsigned fst;
        int unsigned itv;
        deb = sb.deb_len_ms;
        fst = sb.first_delay_ms;
        itv = sb.interval_ms;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:  return $urandom_range(0, deb + 1);
            6, 7, 8, 9, 10:    return $urandom_range(deb, deb * 2);
            11, 12, 13, 14:    return $urandom_range(0, itv * 2);
            15, 16, 17:        return $urandom_range(0, fst + deb);
            18:                return $urandom_range(0, 32'h7FFF_FFFF);
            default:           return $urandom;
        endcase
    endfunction

    task automatic press_sequence();
        logic [1:0] b;
        int n;
        b = 2'($urandom_range(1, 3));
        now_cur += pick_gap();
        // contact bounce
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            send_sample(now_cur, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            now_cur += $urandom_range(0, sb.deb_len_ms / 2);
        end
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            send_sample(now_cur, b[0], b[1]);
            now_cur += pick_gap();
        end
        if (b == bda_pkg::BTN_CHORD && $urandom_range(0, 1) == 1)
        begin
            b = $urandom_range(0, 1) ? 2'(bda_pkg::BTN_DEC) : 2'(bda_pkg::BTN_INC);
            n = $urandom_range(1, 2);
            repeat (n)
            begin
                send_sample(now_cur, b[0], b[1]);
                now_cur += pick_gap();
            end
        end
        n = $urandom_range(1, 2);
        repeat (n)
        begin
            send_sample(now_cur, 1'b0, 1'b0);
            now_cur += pick_gap();
        end
    endtask

    initial
    begin
        bda_pkg::cfg_t deb_tab[NUM_PHASES];
        bda_pkg::cfg_t fst_tab[NUM_PHASES];
        bda_pkg::cfg_t itv_tab[NUM_PHASES];
        int target;

        deb_tab = '{16'd20, 16'd1, 16'd65535, 16'd300, 16'd5, 16'd0};
        fst_tab = '{16'd500, 16'd1, 16'd65535, 16'd50, 16'd40, 16'd0};
        itv_tab = '{16'd100, 16'd1, 16'd65535, 16'd7, 16'd3, 16'd0};
        deb_tab[5] = bda_pkg::cfg_t'($urandom_range(1, 1000));
        fst_tab[5] = bda_pkg::cfg_t'($urandom_range(1, 1000));
        itv_tab[5] = bda_pkg::cfg_t'($urandom_range(1, 1000));

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.now_ms      = '0;
        in_ch.dec_pressed = 1'b0;
        in_ch.inc_pressed = 1'b0;
        out_ch.ready      = 1'b0;
        in_idle           = 1'b1;
        out_idle          = 1'b1;
        sent              = 0;
        cycle_count       = 0;
        now_cur           = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: lockout at reset, release in debounce, repeats, chord, wrap
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 1'b1, 1'b1);
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'd0, 1'b1, 1'b0);
        send_sample(32'd10, 1'b0, 1'b0);
        send_sample(32'd20, 1'b0, 1'b0);
        send_sample(32'd30, 1'b0, 1'b1);
        send_sample(32'd40, 1'b0, 1'b1);
        send_sample(32'd60, 1'b0, 1'b1);
        send_sample(32'd540, 1'b0, 1'b1);
        send_sample(32'd640, 1'b0, 1'b1);
        send_sample(32'd700, 1'b1, 1'b1);
        send_sample(32'd720, 1'b1, 1'b1);
        send_sample(32'd2000, 1'b1, 1'b1);
        send_sample(32'd2001, 1'b1, 1'b0);
        send_sample(32'd2002, 1'b0, 1'b0);
        send_sample(32'd2100, 1'b1, 1'b0);
        send_sample(32'd2110, 1'b0, 1'b1);
        send_sample(32'd2130, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFF0, 1'b1, 1'b0);
        send_sample(32'h8000_0004, 1'b1, 1'b0);
        send_sample(32'h8000_01E4, 1'b1, 1'b0);
        send_sample(32'h8000_0250, 1'b0, 1'b0);
        send_sample(32'hFFFF_FFF0, 1'b0, 1'b1);
        send_sample(32'h0000_0004, 1'b0, 1'b1);
        send_sample(32'h0000_01E4, 1'b0, 1'b1);
        send_sample(32'h0000_01F0, 1'b0, 1'b0);
        now_cur = 32'h0000_0400;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // registers change only with nothing in flight
            in_ch.valid <= 1'b0;
            drain_results();
            write_cfg(bda_pkg::REG_DEBOUNCE_TIME, deb_tab[p]);
            write_cfg(bda_pkg::REG_FIRST_REPEAT_DELAY, fst_tab[p]);
            write_cfg(bda_pkg::REG_REPEAT_INTERVAL, itv_tab[p]);
            if (p == 3)
                write_cfg(REG_SPARE, bda_pkg::cfg_t'($urandom));
            cfg_we <= 1'b0;
            in_idle  = (p != 2);
            out_idle = (p != 2);
            target = sent + ITEMS_PER_PHASE;
            while (sent < target)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    press_sequence();
                end
                else
                begin
                    now_cur += pick_gap();
                    send_sample(now_cur, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end

        in_ch.valid <= 1'b0;
        drain_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
